// ----- rtl/core/rtpf_pkg.sv -----
// Package for the markup-to-plain-text filter: widths, character codes,
// mode encoding, name buffer control and match structs, whitespace test.
// Depends on nothing; every other file of the block uses it.
package rtpf_pkg;

    localparam int CHAR_W         = 16;
    localparam int NAME_CHARS_DEF = 4;

    typedef logic [CHAR_W-1:0] t_char;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_TAG    = 2'd1,
        MODE_ENTITY = 2'd2
    } t_mode;

    // Character codes used by the parser and the name matcher.
    localparam t_char CH_LF    = 16'h000A;
    localparam t_char CH_SPACE = 16'h0020;
    localparam t_char CH_QUOT  = 16'h0022;
    localparam t_char CH_AMP   = 16'h0026;
    localparam t_char CH_APOS  = 16'h0027;
    localparam t_char CH_SLASH = 16'h002F;
    localparam t_char CH_SEMI  = 16'h003B;
    localparam t_char CH_LT    = 16'h003C;
    localparam t_char CH_GT    = 16'h003E;
    localparam t_char CH_NBSP  = 16'h00A0;
    localparam t_char CH_A     = 16'h0061;
    localparam t_char CH_B     = 16'h0062;
    localparam t_char CH_G     = 16'h0067;
    localparam t_char CH_L     = 16'h006C;
    localparam t_char CH_M     = 16'h006D;
    localparam t_char CH_O     = 16'h006F;
    localparam t_char CH_P     = 16'h0070;
    localparam t_char CH_Q     = 16'h0071;
    localparam t_char CH_R     = 16'h0072;
    localparam t_char CH_S     = 16'h0073;
    localparam t_char CH_T     = 16'h0074;
    localparam t_char CH_U     = 16'h0075;

    // Control from the parser to the name buffer.
    typedef struct packed {
        logic  clear;
        logic  push;
        t_char code;
    } t_name_ctl;

    // Which known names the buffer currently holds.
    typedef struct packed {
        logic br;
        logic p;
        logic endp;
        logic amp;
        logic lt;
        logic gt;
        logic quot;
        logic apos;
    } t_name_match;

    function automatic logic is_white(input t_char c);
        logic w;
        w = ((c >= 16'h0009) && (c <= 16'h000D)) ||
            (c == 16'h0020) || (c == 16'h0085) || (c == 16'h00A0) ||
            (c == 16'h1680) ||
            ((c >= 16'h2000) && (c <= 16'h200A)) ||
            (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
            (c == 16'h205F) || (c == 16'h3000);
        return w;
    endfunction

endpackage

// ----- rtl/core/rtpf_if.sv -----
// Valid/ready channel interfaces for the filter's input and result words.
// Depends on rtpf_pkg for the character type.
interface rtpf_in_if;
    logic           valid;
    logic           ready;
    rtpf_pkg::t_char in_char;
    logic           last_char;

    modport source (output valid, output in_char, output last_char, input ready);
    modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

interface rtpf_out_if;
    logic           valid;
    logic           ready;
    rtpf_pkg::t_char out_char;
    logic           char_valid;
    logic           end_of_text;

    modport source (output valid, output out_char, output char_valid,
                    output end_of_text, input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input end_of_text, output ready);
endinterface

// ----- rtl/core/rtpf_name_buf.sv -----
// Tag and entity name buffer: stores the first name characters, tracks the
// count and overflow, and compares the contents against the known names.
// Depends on rtpf_pkg.
module rtpf_name_buf #(
    parameter int NAME_CHARS = rtpf_pkg::NAME_CHARS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rtpf_pkg::t_name_ctl    i_ctl,
    output rtpf_pkg::t_name_match  o_match
);

    localparam int CNT_W = $clog2(NAME_CHARS + 1);
    localparam int IDX_W = $clog2(NAME_CHARS);

    rtpf_pkg::t_char r_store [NAME_CHARS];
    logic [CNT_W-1:0] r_count;
    logic             r_too_long;
    logic             n_has_room;

    assign n_has_room = (r_count < CNT_W'(NAME_CHARS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_too_long <= 1'b0;
        end else if (i_ctl.clear) begin
            r_count    <= '0;
            r_too_long <= 1'b0;
        end else if (i_ctl.push) begin
            if (n_has_room) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_too_long <= 1'b1;
            end
        end
    end

    // Contents need no reset: only entries below the count are ever compared.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.clear && n_has_room) begin
            r_store[r_count[IDX_W-1:0]] <= i_ctl.code;
        end
    end

    always_comb begin
        o_match.br   = !r_too_long && (r_count == CNT_W'(2)) &&
                       (r_store[0] == rtpf_pkg::CH_B) && (r_store[1] == rtpf_pkg::CH_R);
        o_match.p    = !r_too_long && (r_count == CNT_W'(1)) &&
                       (r_store[0] == rtpf_pkg::CH_P);
        o_match.endp = !r_too_long && (r_count == CNT_W'(2)) &&
                       (r_store[0] == rtpf_pkg::CH_SLASH) && (r_store[1] == rtpf_pkg::CH_P);
        o_match.amp  = !r_too_long && (r_count == CNT_W'(3)) &&
                       (r_store[0] == rtpf_pkg::CH_A) && (r_store[1] == rtpf_pkg::CH_M) &&
                       (r_store[2] == rtpf_pkg::CH_P);
        o_match.lt   = !r_too_long && (r_count == CNT_W'(2)) &&
                       (r_store[0] == rtpf_pkg::CH_L) && (r_store[1] == rtpf_pkg::CH_T);
        o_match.gt   = !r_too_long && (r_count == CNT_W'(2)) &&
                       (r_store[0] == rtpf_pkg::CH_G) && (r_store[1] == rtpf_pkg::CH_T);
        o_match.quot = !r_too_long && (r_count == CNT_W'(4)) &&
                       (r_store[0] == rtpf_pkg::CH_Q) && (r_store[1] == rtpf_pkg::CH_U) &&
                       (r_store[2] == rtpf_pkg::CH_O) && (r_store[3] == rtpf_pkg::CH_T);
        o_match.apos = !r_too_long && (r_count == CNT_W'(4)) &&
                       (r_store[0] == rtpf_pkg::CH_A) && (r_store[1] == rtpf_pkg::CH_P) &&
                       (r_store[2] == rtpf_pkg::CH_O) && (r_store[3] == rtpf_pkg::CH_S);
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NAME_CHARS))
        else $error("name count beyond buffer depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> (r_count == CNT_W'(NAME_CHARS)))
        else $error("name overflow flagged with room left");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> ((r_count == '0) && !r_too_long))
        else $error("name buffer not emptied by a clear");
`endif

endmodule

// ----- rtl/core/rich_text_to_plain_filter.sv -----
// Top level of the markup-to-plain-text filter: input register, parser
// state machine and result register. Depends on rtpf_pkg, the channel
// interfaces in rtpf_if.sv and rtpf_name_buf.
//
// The filter takes one UTF-16 code unit per word and turns markup into plain
// text. Tags between '<' and '>' are dropped; a tag named br gives a newline,
// and p or /p give a newline once some output exists (the name ends at the
// first space). Entities between '&' and ';' decode amp, lt, gt, quot and
// apos; any other entity vanishes. A no-break space becomes a space, an input
// newline is dropped, and other whitespace becomes one space unless the last
// character emitted was a space. A word with last_char set always produces a
// result word with end_of_text set (carrying that step's character if there
// is one) and returns the filter to its reset state, so a tag or entity left
// open swallows the rest of its text. Words that produce no character and do
// not end the text produce no result word. Throughput is one input word per
// clock cycle unless the output stalls: each word is held in an input
// register, the parser updates its state and the name buffer in a single
// pass, and any result lands in an output register, from which the sink
// takes it. Input ready only falls while the output register holds a result
// that the sink has not taken and a further word is waiting to be parsed.
module rich_text_to_plain_filter #(
    parameter int NAME_CHARS = rtpf_pkg::NAME_CHARS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rtpf_in_if.sink        i_in,
    rtpf_out_if.source     o_out
);

    // Input register.
    logic             r_in_valid;
    rtpf_pkg::t_char  r_in_char;
    logic             r_in_last;

    // Parser state.
    rtpf_pkg::t_mode  r_mode;
    rtpf_pkg::t_mode  n_mode;
    logic             r_name_ended;
    logic             n_name_ended;
    logic             r_out_started;
    logic             n_out_started;
    logic             r_last_space;
    logic             n_last_space;

    // Result register.
    logic             r_out_valid;
    rtpf_pkg::t_char  r_out_char;
    logic             r_out_chv;
    logic             r_out_eot;

    logic                   advance;
    logic                   step;
    logic                   emit;
    rtpf_pkg::t_char        emit_char;
    rtpf_pkg::t_name_ctl    name_ctl;
    rtpf_pkg::t_name_match  match;

    // The parsed word moves on when the result register is free or being
    // emptied this cycle; a new word enters when the input register is free
    // or its word moves on.
    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_char <= i_in.in_char;
            r_in_last <= i_in.last_char;
        end
    end

    rtpf_name_buf #(
        .NAME_CHARS (NAME_CHARS)
    ) u_name_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (name_ctl),
        .o_match (match)
    );

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= rtpf_pkg::MODE_PLAIN;
            r_name_ended  <= 1'b0;
            r_out_started <= 1'b0;
            r_last_space  <= 1'b0;
        end else if (step) begin
            r_mode        <= n_mode;
            r_name_ended  <= n_name_ended;
            r_out_started <= n_out_started;
            r_last_space  <= n_last_space;
        end
    end

    // Next state and the character, if any, that this word produces.
    always_comb begin
        n_mode        = r_mode;
        n_name_ended  = r_name_ended;
        n_out_started = r_out_started;
        n_last_space  = r_last_space;
        emit          = 1'b0;
        emit_char     = '0;
        name_ctl      = '{clear: 1'b0, push: 1'b0, code: r_in_char};

        unique case (r_mode)
            rtpf_pkg::MODE_TAG: begin
                if (r_in_char == rtpf_pkg::CH_GT) begin
                    if (match.br || ((match.p || match.endp) && r_out_started)) begin
                        emit      = 1'b1;
                        emit_char = rtpf_pkg::CH_LF;
                    end
                    n_mode = rtpf_pkg::MODE_PLAIN;
                end else if (!r_name_ended) begin
                    if (r_in_char == rtpf_pkg::CH_SPACE) begin
                        n_name_ended = 1'b1;
                    end else begin
                        name_ctl.push = 1'b1;
                    end
                end
            end
            rtpf_pkg::MODE_ENTITY: begin
                if (r_in_char == rtpf_pkg::CH_SEMI) begin
                    emit = 1'b1;
                    if (match.amp) begin
                        emit_char = rtpf_pkg::CH_AMP;
                    end else if (match.lt) begin
                        emit_char = rtpf_pkg::CH_LT;
                    end else if (match.gt) begin
                        emit_char = rtpf_pkg::CH_GT;
                    end else if (match.quot) begin
                        emit_char = rtpf_pkg::CH_QUOT;
                    end else if (match.apos) begin
                        emit_char = rtpf_pkg::CH_APOS;
                    end else begin
                        emit = 1'b0;
                    end
                    n_mode = rtpf_pkg::MODE_PLAIN;
                end else begin
                    name_ctl.push = 1'b1;
                end
            end
            default: begin
                // Plain text, and the unused mode code behaves the same.
                if (r_in_char == rtpf_pkg::CH_LT) begin
                    n_mode         = rtpf_pkg::MODE_TAG;
                    n_name_ended   = 1'b0;
                    name_ctl.clear = 1'b1;
                end else if (r_in_char == rtpf_pkg::CH_AMP) begin
                    n_mode         = rtpf_pkg::MODE_ENTITY;
                    n_name_ended   = 1'b0;
                    name_ctl.clear = 1'b1;
                end else if (rtpf_pkg::is_white(r_in_char)) begin
                    if (r_in_char == rtpf_pkg::CH_NBSP) begin
                        emit      = 1'b1;
                        emit_char = rtpf_pkg::CH_SPACE;
                    end else if ((r_in_char != rtpf_pkg::CH_LF) && !r_last_space) begin
                        emit      = 1'b1;
                        emit_char = rtpf_pkg::CH_SPACE;
                    end
                end else begin
                    emit      = 1'b1;
                    emit_char = r_in_char;
                end
            end
        endcase

        if (emit) begin
            n_out_started = 1'b1;
            n_last_space  = (emit_char == rtpf_pkg::CH_SPACE);
        end

        // The final word of a text returns everything to its reset state.
        if (r_in_last) begin
            n_mode         = rtpf_pkg::MODE_PLAIN;
            n_name_ended   = 1'b0;
            n_out_started  = 1'b0;
            n_last_space   = 1'b0;
            name_ctl.clear = 1'b1;
        end

        // The buffer only changes on a step that actually happens.
        name_ctl.clear = name_ctl.clear && step;
        name_ctl.push  = name_ctl.push && step;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && (emit || r_in_last)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && (emit || r_in_last)) begin
            r_out_char <= emit ? emit_char : '0;
            r_out_chv  <= emit;
            r_out_eot  <= r_in_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.char_valid  = r_out_chv;
    assign o_out.end_of_text = r_out_eot;

`ifndef SYNTH
    a_empty_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_chv) |-> r_out_eot)
        else $error("result word without character does not end the text");

    a_empty_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_chv) |-> (r_out_char == '0))
        else $error("result word without character carries a non-zero code");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_last) |=>
            ((r_mode == rtpf_pkg::MODE_PLAIN) && !r_out_started && !r_last_space))
        else $error("parser state not cleared after the final word of a text");

    a_space_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit && !r_in_last) |=>
            (r_out_started && (r_last_space == (r_out_char == rtpf_pkg::CH_SPACE))))
        else $error("space tracking disagrees with the emitted character");
`endif

endmodule
